// ===== src/pea_pkg.sv =====
// ---------------------------------------------------------------------------
// pea_pkg
// Types, widths and codes shared by the page extent allocator.
// ---------------------------------------------------------------------------
package pea_pkg;

	localparam int MAX_EXTENTS = 64;
	localparam int PAGE_W      = 20;
	localparam int LEN_W       = PAGE_W + 1;
	localparam int IDX_W       = $clog2(MAX_EXTENTS);
	localparam int CNT_W       = IDX_W + 1;
	localparam int CFG_IDX_W   = 1;

	localparam logic [CFG_IDX_W-1:0] CFG_POOL_BASE  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_POOL_COUNT = 1'd1;

	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_FREE  = 1'b1;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_NOFIT = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;
	localparam logic [1:0] ST_ZERO  = 2'd3;

	typedef struct packed {
		logic              cmd;
		logic [LEN_W-1:0]  page_count;
		logic [PAGE_W-1:0] start_page;
	} req_t;

	typedef struct packed {
		logic              granted;
		logic [PAGE_W-1:0] alloc_page;
		logic [1:0]        status;
	} rsp_t;

	typedef struct packed {
		logic [PAGE_W-1:0] start;
		logic [LEN_W-1:0]  len;
	} ent_t;

	localparam int ENT_W = $bits(ent_t);

	function automatic logic [LEN_W-1:0] sat_len(input logic [LEN_W+1:0] v);
		sat_len = (v > {2'b00, {LEN_W{1'b1}}}) ? {LEN_W{1'b1}} : v[LEN_W-1:0];
	endfunction

endpackage

// ===== src/pea_ram.sv =====
// ---------------------------------------------------------------------------
// pea_ram
// Generic single write port, single read port RAM with registered read.
// ---------------------------------------------------------------------------
module pea_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== src/page_extent_allocator.sv =====
// ---------------------------------------------------------------------------
// page_extent_allocator
// First-fit page allocator over an address-ordered free extent table.
// ---------------------------------------------------------------------------
// Requests arrive on req (valid/ready): cmd 0 allocates page_count pages,
// cmd 1 frees page_count pages at start_page. Each request gives one
// response on rsp (valid/ready). The free extent table lives in one RAM
// with a registered read; a sequencer walks it one entry at a time.
// Allocate: scan to the first fitting entry, then a tail update or a shift
// down of the rest of the table. Free: scan to the insert point, then a
// merge write, a shift down, or a shift up to open a slot (status full if
// no slot is left). The block takes one request at a time and req_ready
// is low while it works. A finished response waits in the rsp register
// when the receiver stalls; the next request may be taken meanwhile but
// cannot complete until it drains. cfg writes (index 0 pool base, 1 pool
// count) are taken only when the sequencer is idle, win over a waiting
// request, and reload the table with one extent covering the pool (none
// if the count is zero). Reset clears the state, counters and pool
// settings, not the captured request or rsp; the table starts empty.
// ---------------------------------------------------------------------------
module page_extent_allocator (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             req_valid,
	output logic                             req_ready,
	input  pea_pkg::req_t                    req,
	output logic                             rsp_valid,
	input  logic                             rsp_ready,
	output pea_pkg::rsp_t                    rsp,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [pea_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [pea_pkg::LEN_W-1:0]        cfg_data
);

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_A_RD  = 4'd1;
	localparam logic [3:0] S_A_EV  = 4'd2;
	localparam logic [3:0] S_SH_RD = 4'd3;
	localparam logic [3:0] S_SH_WR = 4'd4;
	localparam logic [3:0] S_F_RD  = 4'd5;
	localparam logic [3:0] S_F_EV  = 4'd6;
	localparam logic [3:0] S_F_DEC = 4'd7;
	localparam logic [3:0] S_UP_RD = 4'd8;
	localparam logic [3:0] S_UP_WR = 4'd9;
	localparam logic [3:0] S_FIN   = 4'd10;

	localparam int PW = pea_pkg::PAGE_W;
	localparam int LW = pea_pkg::LEN_W;
	localparam int IW = pea_pkg::IDX_W;
	localparam int CW = pea_pkg::CNT_W;

	logic [3:0]          state_q;
	logic [CW-1:0]       used_q, k_q, j_q;
	logic                cmd_q;
	logic [LW-1:0]       cnt_q;
	logic [PW-1:0]       s_q;
	logic [PW-1:0]       page_q;
	logic [1:0]          status_q;
	pea_pkg::ent_t       prev_q, nxt_q;
	logic                nxt_ok_q;
	logic [PW-1:0]       base_q;
	logic [LW-1:0]       count_q;
	logic                rsp_valid_q;
	pea_pkg::rsp_t       rsp_q;

	logic                ram_we;
	logic [IW-1:0]       ram_waddr, ram_raddr;
	pea_pkg::ent_t       ram_wdata, ram_rdata;

	logic                join_next, join_prev;
	logic [PW-1:0]       new_base;
	logic [LW-1:0]       new_count;

	pea_ram #(.WIDTH(pea_pkg::ENT_W), .DEPTH(pea_pkg::MAX_EXTENTS)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign req_ready = (state_q == S_IDLE) && !cfg_valid;
	assign cfg_ready = (state_q == S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	assign new_base  = (cfg_index == pea_pkg::CFG_POOL_BASE) ? cfg_data[PW-1:0] : base_q;
	assign new_count = (cfg_index == pea_pkg::CFG_POOL_COUNT) ? cfg_data : count_q;

	assign join_next = nxt_ok_q &&
		(({2'b00, s_q} + {1'b0, cnt_q}) == {2'b00, nxt_q.start});
	assign join_prev = (k_q != '0) &&
		(({2'b00, prev_q.start} + {1'b0, prev_q.len}) == {2'b00, s_q});

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = k_q[IW-1:0];
		ram_wdata = '0;
		ram_raddr = k_q[IW-1:0];
		unique case (state_q)
			S_IDLE: begin
				if (cfg_valid) begin
					ram_we    = 1'b1;
					ram_waddr = '0;
					ram_wdata = '{start: new_base, len: new_count};
				end
			end
			S_A_EV: begin
				if (ram_rdata.len > cnt_q) begin
					ram_we    = 1'b1;
					ram_wdata.start = PW'({1'b0, ram_rdata.start} + cnt_q);
					ram_wdata.len   = ram_rdata.len - cnt_q;
				end
			end
			S_SH_RD: ram_raddr = IW'(k_q + 1'b1);
			S_SH_WR: begin
				ram_we    = 1'b1;
				ram_wdata = ram_rdata;
			end
			S_F_DEC: begin
				if (join_prev) begin
					ram_we    = 1'b1;
					ram_waddr = IW'(k_q - 1'b1);
					ram_wdata.start = prev_q.start;
					ram_wdata.len   = join_next ?
						pea_pkg::sat_len({2'b00, prev_q.len} + {2'b00, cnt_q} +
							{2'b00, nxt_q.len}) :
						pea_pkg::sat_len({2'b00, prev_q.len} + {2'b00, cnt_q});
				end else if (join_next) begin
					ram_we    = 1'b1;
					ram_wdata.start = s_q;
					ram_wdata.len   = pea_pkg::sat_len({2'b00, nxt_q.len} + {2'b00, cnt_q});
				end
			end
			S_UP_RD: begin
				ram_raddr = IW'(j_q - 1'b1);
				if (j_q == k_q) begin
					ram_we    = 1'b1;
					ram_wdata = '{start: s_q, len: cnt_q};
				end
			end
			S_UP_WR: begin
				ram_we    = 1'b1;
				ram_waddr = j_q[IW-1:0];
				ram_wdata = ram_rdata;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			used_q      <= '0;
			k_q         <= '0;
			j_q         <= '0;
			page_q      <= '0;
			status_q    <= pea_pkg::ST_OK;
			prev_q      <= '0;
			nxt_q       <= '0;
			nxt_ok_q    <= 1'b0;
			base_q      <= '0;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (state_q == S_FIN && (!rsp_valid_q || rsp_ready)) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (cfg_valid) begin
						base_q  <= new_base;
						count_q <= new_count;
						used_q  <= (new_count != '0) ? CW'(1) : '0;
					end else if (req_valid) begin
						k_q    <= '0;
						page_q <= '0;
						if (req.page_count == '0) begin
							status_q <= pea_pkg::ST_ZERO;
							state_q  <= S_FIN;
						end else if (req.cmd == pea_pkg::CMD_ALLOC) begin
							state_q <= S_A_RD;
						end else begin
							state_q <= S_F_RD;
						end
					end
				end
				S_A_RD: begin
					if (k_q >= used_q) begin
						status_q <= pea_pkg::ST_NOFIT;
						state_q  <= S_FIN;
					end else begin
						state_q <= S_A_EV;
					end
				end
				S_A_EV: begin
					if (ram_rdata.len >= cnt_q) begin
						page_q   <= ram_rdata.start;
						status_q <= pea_pkg::ST_OK;
						state_q  <= (ram_rdata.len > cnt_q) ? S_FIN : S_SH_RD;
					end else begin
						k_q     <= k_q + 1'b1;
						state_q <= S_A_RD;
					end
				end
				S_SH_RD: begin
					if (CW'(k_q + 1'b1) >= used_q) begin
						used_q  <= used_q - 1'b1;
						state_q <= S_FIN;
					end else begin
						state_q <= S_SH_WR;
					end
				end
				S_SH_WR: begin
					k_q     <= k_q + 1'b1;
					state_q <= S_SH_RD;
				end
				S_F_RD: begin
					if (k_q >= used_q) begin
						nxt_ok_q <= 1'b0;
						state_q  <= S_F_DEC;
					end else begin
						state_q <= S_F_EV;
					end
				end
				S_F_EV: begin
					if (ram_rdata.start < s_q) begin
						prev_q  <= ram_rdata;
						k_q     <= k_q + 1'b1;
						state_q <= S_F_RD;
					end else begin
						nxt_q    <= ram_rdata;
						nxt_ok_q <= 1'b1;
						state_q  <= S_F_DEC;
					end
				end
				S_F_DEC: begin
					status_q <= pea_pkg::ST_OK;
					if (join_prev && join_next) begin
						state_q <= S_SH_RD;
					end else if (join_prev || join_next) begin
						state_q <= S_FIN;
					end else if (used_q >= CW'(pea_pkg::MAX_EXTENTS)) begin
						status_q <= pea_pkg::ST_FULL;
						state_q  <= S_FIN;
					end else begin
						j_q     <= used_q;
						state_q <= S_UP_RD;
					end
				end
				S_UP_RD: begin
					if (j_q == k_q) begin
						used_q  <= used_q + 1'b1;
						state_q <= S_FIN;
					end else begin
						state_q <= S_UP_WR;
					end
				end
				S_UP_WR: begin
					j_q     <= j_q - 1'b1;
					state_q <= S_UP_RD;
				end
				S_FIN: begin
					if (!rsp_valid_q || rsp_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && !cfg_valid && req_valid) begin
			cmd_q <= req.cmd;
			cnt_q <= req.page_count;
			s_q   <= req.start_page;
		end
		if (state_q == S_FIN && (!rsp_valid_q || rsp_ready)) begin
			rsp_q.granted    <= (status_q == pea_pkg::ST_OK);
			rsp_q.alloc_page <= (status_q == pea_pkg::ST_OK && cmd_q == pea_pkg::CMD_ALLOC) ?
				page_q : '0;
			rsp_q.status     <= status_q;
		end
	end

endmodule

// ===== src/pea_chk.sv =====
// ---------------------------------------------------------------------------
// pea_chk
// Port-level checks for the page extent allocator.
// ---------------------------------------------------------------------------
module pea_chk (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          req_valid,
	input logic                          req_ready,
	input logic                          rsp_valid,
	input logic                          rsp_ready,
	input pea_pkg::rsp_t                 rsp
);

	a_granted: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp.granted == (rsp.status == pea_pkg::ST_OK)))
		else $error("granted disagrees with status");

	a_page_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp.granted) |-> (rsp.alloc_page == '0))
		else $error("alloc_page nonzero on a failed request");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready) |=> !req_ready)
		else $error("ready right after a request was taken");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp)))
		else $error("stalled response changed");

endmodule

bind page_extent_allocator pea_chk u_pea_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_ready (req_ready),
	.rsp_valid (rsp_valid),
	.rsp_ready (rsp_ready),
	.rsp       (rsp)
);

// ===== sim/page_extent_allocator_tb.sv =====
// ---------------------------------------------------------------------------
// page_extent_allocator_tb
// Self-checking bench for the first-fit page extent allocator.
// ---------------------------------------------------------------------------
// Keeps its own copy of the free extent table and predicts one response per
// request. Runs directed corner requests, then alloc/free traffic over several
// pool settings, including a fragmentation pass that fills the table.
// Both channels see random idle bursts; the last phase runs without them.
// ---------------------------------------------------------------------------
module page_extent_allocator_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 3000000;

	class extent_scoreboard;
		pea_pkg::ent_t                     free_ext[$];
		logic [pea_pkg::PAGE_W-1:0]        pool_base;
		logic [pea_pkg::LEN_W-1:0]         pool_pages;
		pea_pkg::rsp_t                     expected_q[$];
		int                                failures;
		int                                mismatches;

		function new();
			pool_base  = '0;
			pool_pages = '0;
			failures   = 0;
			mismatches = 0;
		endfunction

		function void reload();
			pea_pkg::ent_t e;
			free_ext.delete();
			if (pool_pages != 0) begin
				e.start = pool_base;
				e.len   = pool_pages;
				free_ext.push_back(e);
			end
		endfunction

		function void write_reg(logic [pea_pkg::CFG_IDX_W-1:0] idx,
				logic [pea_pkg::LEN_W-1:0] d);
			if (idx == pea_pkg::CFG_POOL_BASE)
				pool_base = d[pea_pkg::PAGE_W-1:0];
			else
				pool_pages = d;
			reload();
		endfunction

		function logic [pea_pkg::LEN_W-1:0] clamp(logic [pea_pkg::LEN_W+1:0] v);
			return (v > {2'b00, {pea_pkg::LEN_W{1'b1}}}) ?
				{pea_pkg::LEN_W{1'b1}} : v[pea_pkg::LEN_W-1:0];
		endfunction

		function pea_pkg::rsp_t note(pea_pkg::req_t r);
			pea_pkg::rsp_t               e;
			pea_pkg::ent_t               n;
			int                          i;
			bit                          jn, jp, found;
			logic [pea_pkg::LEN_W+1:0]   sum;
			e = '0;
			found = 0;
			if (r.page_count == 0) begin
				e.status = pea_pkg::ST_ZERO;
			end else if (r.cmd == pea_pkg::CMD_ALLOC) begin
				e.status = pea_pkg::ST_NOFIT;
				for (i = 0; i < free_ext.size() && !found; i++) begin
					if (free_ext[i].len >= r.page_count) begin
						found = 1;
						e.granted    = 1'b1;
						e.status     = pea_pkg::ST_OK;
						e.alloc_page = free_ext[i].start;
						if (free_ext[i].len > r.page_count) begin
							free_ext[i].start = free_ext[i].start +
								r.page_count[pea_pkg::PAGE_W-1:0];
							free_ext[i].len   = free_ext[i].len - r.page_count;
						end else begin
							free_ext.delete(i);
						end
					end
				end
			end else begin
				i = 0;
				while (i < free_ext.size() && free_ext[i].start < r.start_page)
					i++;
				sum = {2'b00, r.start_page} + r.page_count;
				jn = (i < free_ext.size()) && (sum == {2'b00, free_ext[i].start});
				jp = 0;
				if (i > 0) begin
					sum = {2'b00, free_ext[i-1].start} + free_ext[i-1].len;
					jp = (sum == {2'b00, r.start_page});
				end
				e.status  = pea_pkg::ST_OK;
				e.granted = 1'b1;
				if (jp && jn) begin
					sum = {1'b0, free_ext[i-1].len} + r.page_count + free_ext[i].len;
					free_ext[i-1].len = clamp(sum);
					free_ext.delete(i);
				end else if (jp) begin
					free_ext[i-1].len = clamp({1'b0, free_ext[i-1].len} + r.page_count);
				end else if (jn) begin
					free_ext[i].start = r.start_page;
					free_ext[i].len   = clamp({1'b0, free_ext[i].len} + r.page_count);
				end else if (free_ext.size() >= pea_pkg::MAX_EXTENTS) begin
					e.status  = pea_pkg::ST_FULL;
					e.granted = 1'b0;
				end else begin
					n.start = r.start_page;
					n.len   = r.page_count;
					free_ext.insert(i, n);
				end
			end
			expected_q.push_back(e);
			return e;
		endfunction

		function void check(pea_pkg::rsp_t a);
			pea_pkg::rsp_t e;
			if (expected_q.size() == 0) begin
				failures++;
				if (mismatches++ < 10)
					$display("unexpected response %p", a);
				return;
			end
			e = expected_q.pop_front();
			if (a.granted !== e.granted || a.alloc_page !== e.alloc_page
					|| a.status !== e.status) begin
				failures++;
				if (mismatches++ < 10)
					$display("mismatch: expected %p, got %p", e, a);
			end
		endfunction
	endclass

	logic                              clk;
	logic                              arst_n;
	logic                              req_valid;
	logic                              req_ready;
	pea_pkg::req_t                     req;
	logic                              rsp_valid;
	logic                              rsp_ready;
	pea_pkg::rsp_t                     rsp;
	logic                              cfg_valid;
	logic                              cfg_ready;
	logic [pea_pkg::CFG_IDX_W-1:0]     cfg_index;
	logic [pea_pkg::LEN_W-1:0]         cfg_data;

	extent_scoreboard  sb;
	bit                idling;
	int                stall_left;
	int                cycles;
	pea_pkg::ent_t     held[$];

	page_extent_allocator uut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_ready(req_ready), .req(req),
		.rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp_valid && rsp_ready)
			sb.check(rsp);
		if (stall_left > 0) begin
			stall_left--;
			rsp_ready <= 1'b0;
		end else if (idling && $urandom_range(0, 5) == 0) begin
			stall_left = $urandom_range(1, 7) - 1;
			rsp_ready <= 1'b0;
		end else begin
			rsp_ready <= 1'b1;
		end
	end

	task automatic send(logic cmd, logic [pea_pkg::LEN_W-1:0] cnt,
			logic [pea_pkg::PAGE_W-1:0] s);
		pea_pkg::req_t r;
		pea_pkg::rsp_t e;
		pea_pkg::ent_t h;
		r.cmd        = cmd;
		r.page_count = cnt;
		r.start_page = s;
		if (idling && $urandom_range(0, 3) == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
		req_valid <= 1'b1;
		req       <= r;
		do @(posedge clk); while (!req_ready);
		e = sb.note(r);
		if (cmd == pea_pkg::CMD_ALLOC && e.granted) begin
			h.start = e.alloc_page;
			h.len   = cnt;
			held.push_back(h);
		end
	endtask

	task automatic drain();
		req_valid <= 1'b0;
		while (sb.expected_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(logic [pea_pkg::CFG_IDX_W-1:0] idx,
			logic [pea_pkg::LEN_W-1:0] d);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= d;
		do @(posedge clk); while (!cfg_ready);
		sb.write_reg(idx, d);
	endtask

	task automatic set_pool(logic [pea_pkg::PAGE_W-1:0] b, logic [pea_pkg::LEN_W-1:0] n);
		drain();
		@(posedge clk);
		write_reg(pea_pkg::CFG_POOL_BASE, {1'b0, b});
		write_reg(pea_pkg::CFG_POOL_COUNT, n);
		cfg_valid <= 1'b0;
		held.delete();
	endtask

	task automatic free_held(int k);
		pea_pkg::ent_t h;
		h = held[k];
		held.delete(k);
		send(pea_pkg::CMD_FREE, h.len, h.start);
	endtask

	task automatic mixed_traffic(int n);
		int p;
		for (int k = 0; k < n; k++) begin
			p = $urandom_range(0, 99);
			if (p < 45) begin
				if ($urandom_range(0, 9) < 7)
					send(pea_pkg::CMD_ALLOC, 21'($urandom_range(1, 16)), 20'($urandom));
				else if ($urandom_range(0, 3) != 0)
					send(pea_pkg::CMD_ALLOC, 21'($urandom_range(1, 512)), 20'($urandom));
				else
					send(pea_pkg::CMD_ALLOC, 21'($urandom_range(1, 1048576)),
						20'($urandom));
			end else if (p < 88 && held.size() != 0) begin
				free_held($urandom_range(0, held.size() - 1));
			end else if (p < 94) begin
				send(pea_pkg::CMD_FREE, 21'($urandom_range(1, 8)), 20'($urandom));
			end else if (p < 97) begin
				send(pea_pkg::CMD_FREE, 21'($urandom_range(1, 1048576)), 20'($urandom));
			end else begin
				send(1'($urandom_range(0, 1)), '0, 20'($urandom));
			end
		end
	endtask

	initial begin
		sb         = new();
		arst_n     = 1'b0;
		req_valid  = 1'b0;
		req        = '0;
		rsp_ready  = 1'b0;
		cfg_valid  = 1'b0;
		cfg_index  = pea_pkg::CFG_POOL_BASE;
		cfg_data   = '0;
		idling     = 1'b1;
		stall_left = 0;
		cycles     = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty table after reset
		send(pea_pkg::CMD_ALLOC, 21'd1, '0);
		send(pea_pkg::CMD_ALLOC, '0, '0);
		send(pea_pkg::CMD_FREE, '0, 20'hFFFFF);
		// largest pool at the top page
		set_pool(20'hFFFFF, 21'h100000);
		send(pea_pkg::CMD_ALLOC, 21'h100000, '0);
		send(pea_pkg::CMD_ALLOC, 21'd1, '0);
		// splits, merges with next and with both neighbours
		set_pool(20'h80000, 21'h1000);
		send(pea_pkg::CMD_ALLOC, 21'd16, '0);
		send(pea_pkg::CMD_ALLOC, 21'h2000, '0);
		send(pea_pkg::CMD_FREE, 21'd16, 20'h80000);
		send(pea_pkg::CMD_ALLOC, 21'd4, '0);
		send(pea_pkg::CMD_ALLOC, 21'd4, '0);
		send(pea_pkg::CMD_FREE, 21'd4, 20'h80000);
		send(pea_pkg::CMD_FREE, 21'd4, 20'h80004);
		send(pea_pkg::CMD_FREE, 21'd5, 20'h00010);
		send(pea_pkg::CMD_FREE, 21'd5, 20'h00010);
		send(pea_pkg::CMD_FREE, 21'h100000, 20'hFFFFF);
		send(pea_pkg::CMD_FREE, 21'h1FFFFF, 20'h00000);
		// tail start wraps past the page space
		set_pool(20'hFFFF0, 21'h100);
		send(pea_pkg::CMD_ALLOC, 21'd32, '0);
		send(pea_pkg::CMD_ALLOC, 21'h100, '0);
		send(pea_pkg::CMD_ALLOC, 21'hE0, '0);

		set_pool(20'h0, 21'd64);
		mixed_traffic(200);
		set_pool(20'($urandom), 21'($urandom_range(1, 4096)));
		mixed_traffic(200);
		set_pool(20'hFFFFF, 21'h100000);
		mixed_traffic(150);
		set_pool('0, '0);
		mixed_traffic(50);
		set_pool(20'($urandom), 21'h100000);
		mixed_traffic(200);

		// fragment until the table is full, then merge it back
		set_pool(20'd1000, 21'd300);
		for (int k = 0; k < 150; k++)
			send(pea_pkg::CMD_ALLOC, 21'd1, '0);
		for (int k = 0; k < 150; k += 2)
			send(pea_pkg::CMD_FREE, 21'd1, 20'(1000 + k));
		for (int k = 1; k < 150; k += 2)
			send(pea_pkg::CMD_FREE, 21'd1, 20'(1000 + k));

		drain();
		idling = 1'b0;
		set_pool(20'($urandom), 21'($urandom_range(64, 2048)));
		mixed_traffic(150);

		drain();
		repeat (300) @(posedge clk);
		if (sb.failures == 0 && sb.expected_q.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
